/* rtl/core/fdtp_pkg.sv */
// ----------------------------------------------------------------------------
// fdtp_pkg: shared types for the device-tree structure token parser
// Token kinds, the result beat layout and the push bundle that the parser
// hands to the result queue.
// ----------------------------------------------------------------------------
package fdtp_pkg;

	localparam int CFG_W    = 21;  // configuration register width
	localparam int POS_W    = 21;  // byte position width
	localparam int OFF_W    = 20;  // offset fields
	localparam int LEN_W    = 21;  // value length
	localparam int SKIP_W   = 19;  // value words left to skip
	localparam int WORD_W   = 32;

	localparam int Q_DEPTH  = 4;   // result queue entries
	localparam int Q_PTR_W  = 2;
	localparam int Q_CNT_W  = 3;

	// configuration register indexes
	localparam logic [0:0] CFG_STRUCT_BYTES  = 1'b0;
	localparam logic [0:0] CFG_STRINGS_BYTES = 1'b1;

	typedef enum logic [2:0] {
		KIND_BEGIN_NODE = 3'd0,
		KIND_END_NODE   = 3'd1,
		KIND_PROPERTY   = 3'd2,
		KIND_END        = 3'd3,
		KIND_ERROR      = 3'd4
	} token_kind_t;

	typedef struct packed {
		token_kind_t        kind;
		logic [OFF_W-1:0]   name_offset;
		logic [OFF_W-1:0]   data_offset;
		logic [LEN_W-1:0]   data_length;
		logic               last_of_run;
	} result_t;

	// up to two result beats pushed per parsed word
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

/* rtl/core/fdtp_parse.sv */
// ----------------------------------------------------------------------------
// fdtp_parse: per-word parse step and parser state
// Decodes one structure word against the current phase and position, updates
// the state and produces zero, one or two result beats.
// ----------------------------------------------------------------------------
module fdtp_parse #(
	parameter int unsigned MAX_BLOB_BYTES = 1048576
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [fdtp_pkg::WORD_W-1:0]   word,
	input  logic                          start_req,
	input  logic [fdtp_pkg::CFG_W-1:0]    struct_bytes,
	input  logic [fdtp_pkg::CFG_W-1:0]    strings_bytes,
	output fdtp_pkg::push_t               push
);
	import fdtp_pkg::*;

	typedef enum logic [2:0] {
		PH_TOKEN, PH_NAME, PH_PLEN, PH_POFF, PH_SKIP, PH_DONE, PH_ERR
	} phase_t;

	localparam logic [WORD_W-1:0] TOK_BEGIN_NODE = 32'h0000_0001;
	localparam logic [WORD_W-1:0] TOK_END_NODE   = 32'h0000_0002;
	localparam logic [WORD_W-1:0] TOK_PROP       = 32'h0000_0003;
	localparam logic [WORD_W-1:0] TOK_NOP        = 32'h0000_0004;
	localparam logic [WORD_W-1:0] TOK_END        = 32'h0000_0009;

	localparam logic [24:0] MaxBytes = 25'(MAX_BLOB_BYTES);

	phase_t              phase_q, phase_b, phase_d;
	logic [POS_W-1:0]    pos_q, pos_b, pos_d;
	logic [SKIP_W-1:0]   skip_q, skip_b, skip_d;
	logic [LEN_W-1:0]    hlen_q, hlen_b, hlen_d;
	logic [OFF_W-1:0]    hname_q, hname_b, hname_d;

	logic [CFG_W-1:0]    lim;
	logic [22:0]         lim23, p23, p4, p8, room;
	logic [32:0]         pad;
	logic [21:0]         hlen_rnd;
	logic                zero_byte, prim_v, end_err;
	result_t             prim, err_res;

	assign lim = ({4'b0, struct_bytes} > MaxBytes) ? MaxBytes[CFG_W-1:0] : struct_bytes;
	assign lim23 = {2'b0, lim};

	// start_req restarts the parse before this word is looked at
	always_comb begin
		if (start_req) begin
			phase_b = PH_TOKEN;
			pos_b   = '0;
			skip_b  = '0;
			hlen_b  = '0;
			hname_b = '0;
		end else begin
			phase_b = phase_q;
			pos_b   = pos_q;
			skip_b  = skip_q;
			hlen_b  = hlen_q;
			hname_b = hname_q;
		end
	end

	assign p23  = {2'b0, pos_b};
	assign p4   = p23 + 23'd4;
	assign p8   = p23 + 23'd8;
	assign room = lim23 - p8;
	assign pad  = ({1'b0, word} + 33'd3) & ~33'd3;
	assign hlen_rnd = {1'b0, hlen_b} + 22'd3;
	assign zero_byte = (word[31:24] == 8'd0) || (word[23:16] == 8'd0) ||
	                   (word[15:8] == 8'd0) || (word[7:0] == 8'd0);

	always_comb begin
		err_res = '0;
		err_res.kind = KIND_ERROR;
		err_res.last_of_run = 1'b1;
	end

	always_comb begin
		phase_d = phase_b;
		pos_d   = pos_b;
		skip_d  = skip_b;
		hlen_d  = hlen_b;
		hname_d = hname_b;
		prim_v  = 1'b0;
		prim    = err_res;
		end_err = 1'b0;
		if (phase_b == PH_DONE || phase_b == PH_ERR) begin
			// sticky: drop the word
		end else if (p4 > lim23) begin
			phase_d = PH_ERR;
			prim_v  = 1'b1;
		end else begin
			unique case (phase_b)
				PH_TOKEN: begin
					case (word)
						TOK_BEGIN_NODE: begin
							hname_d = p4[OFF_W-1:0];
							phase_d = PH_NAME;
						end
						TOK_END_NODE: begin
							prim_v = 1'b1;
							prim.kind = KIND_END_NODE;
						end
						TOK_PROP: begin
							if (p8 > lim23) begin
								phase_d = PH_ERR;
								prim_v  = 1'b1;
							end else begin
								phase_d = PH_PLEN;
							end
						end
						TOK_NOP: begin
						end
						TOK_END: begin
							phase_d = PH_DONE;
							prim_v  = 1'b1;
							prim.kind = KIND_END;
						end
						default: begin
							phase_d = PH_ERR;
							prim_v  = 1'b1;
						end
					endcase
				end
				PH_NAME: begin
					if (zero_byte) begin
						if (p4 >= lim23) begin
							phase_d = PH_ERR;
							prim_v  = 1'b1;
						end else begin
							phase_d = PH_TOKEN;
							prim_v  = 1'b1;
							prim.kind = KIND_BEGIN_NODE;
							prim.name_offset = hname_b;
						end
					end
				end
				PH_PLEN: begin
					// negative room ends in the block-end error either way
					if (room[22] || (pad > {10'b0, room})) begin
						phase_d = PH_ERR;
						prim_v  = 1'b1;
					end else begin
						hlen_d  = word[LEN_W-1:0];
						phase_d = PH_POFF;
					end
				end
				PH_POFF: begin
					if (word >= {11'b0, strings_bytes}) begin
						phase_d = PH_ERR;
						prim_v  = 1'b1;
					end else begin
						prim_v = 1'b1;
						prim.kind = KIND_PROPERTY;
						prim.name_offset = word[OFF_W-1:0];
						prim.data_offset = p4[OFF_W-1:0];
						prim.data_length = hlen_b;
						skip_d  = hlen_rnd[SKIP_W+1:2];
						phase_d = (hlen_rnd[SKIP_W+1:2] != '0) ? PH_SKIP : PH_TOKEN;
					end
				end
				default: begin
					if (skip_b != '0) begin
						skip_d = skip_b - 1'b1;
					end
					if (skip_b <= SKIP_W'(1)) begin
						phase_d = PH_TOKEN;
					end
				end
			endcase
			pos_d = p4[POS_W-1:0];
			if (phase_d != PH_DONE && phase_d != PH_ERR && p8 > lim23) begin
				phase_d = PH_ERR;
				end_err = 1'b1;
			end
		end
	end

	always_comb begin
		push = '0;
		if (advance) begin
			if (prim_v && end_err) begin
				push.n  = 2'd2;
				push.r0 = prim;
				push.r0.last_of_run = 1'b0;
				push.r1 = err_res;
			end else if (prim_v) begin
				push.n  = 2'd1;
				push.r0 = prim;
				push.r0.last_of_run = 1'b1;
			end else if (end_err) begin
				push.n  = 2'd1;
				push.r0 = err_res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TOKEN;
			pos_q   <= '0;
			skip_q  <= '0;
			hlen_q  <= '0;
			hname_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			skip_q  <= skip_d;
			hlen_q  <= hlen_d;
			hname_q <= hname_d;
		end
	end

`ifndef SYNTHESIS
	a_sticky_silent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !start_req && (phase_q == PH_DONE || phase_q == PH_ERR) |-> push.n == 2'd0)
		else $error("parser emitted a beat after end or error");
	a_second_is_error: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> push.r1.kind == KIND_ERROR && !push.r0.last_of_run)
		else $error("second beat of a word is not a closing error");
	a_pos_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> pos_q[1:0] == 2'b00)
		else $error("byte position lost word alignment");
`endif

endmodule

/* rtl/core/fdtp_result_fifo.sv */
// ----------------------------------------------------------------------------
// fdtp_result_fifo: result queue
// Takes up to two result beats per cycle and hands them out one per beat.
// ----------------------------------------------------------------------------
module fdtp_result_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fdtp_pkg::push_t       push,
	output logic                  room,
	output logic                  out_valid,
	input  logic                  out_ready,
	output fdtp_pkg::result_t     head
);
	import fdtp_pkg::*;

	result_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_q, rd_q, wr_next;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q <= Q_CNT_W'(Q_DEPTH - 2));
	assign head      = mem_q[rd_q];
	assign wr_next   = wr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + Q_PTR_W'(push.n);
			rd_q  <= rd_q + Q_PTR_W'(pop);
			cnt_q <= cnt_q + Q_CNT_W'(push.n) - Q_CNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("result queue overflow");
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room)
		else $error("push without two free entries");
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.n == 2'd0 |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("pop did not drain an entry");
`endif

endmodule

/* rtl/core/fdt_structure_token_parser.sv */
// ----------------------------------------------------------------------------
// fdt_structure_token_parser: device-tree structure block token parser
// Streams structure words in and emits begin_node, end_node, property, end
// and error tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one big-endian structure word
//   per beat; start_req marks the first word of a block and restarts parsing.
//   Output channel (out_valid/out_ready) carries one token per beat;
//   last_of_run marks the final token caused by a word (a word gives zero,
//   one or two tokens).
//   Path: an accepted word is held in the input register, then parsed into
//   the result queue, from which its tokens leave.
//   Throughput: one word per cycle while the queue has room; the parse step is
//   a single registered pass. Two tokens from one word take two output beats.
//   Stall: the four-entry result queue absorbs output stalls; in_ready drops
//   once more than two tokens are queued, and words hold in the input
//   register until the queue drains.
//   Reset: parser restarts at byte zero expecting a token, both size
//   registers read zero, queue empties. After an end or error token later
//   words yield nothing until start_req.
//   Configure struct_bytes and strings_bytes via cfg_we only while idle.
// ----------------------------------------------------------------------------
module fdt_structure_token_parser #(
	parameter int unsigned MAX_BLOB_BYTES = 1048576
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [fdtp_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fdtp_pkg::WORD_W-1:0]   word,
	input  logic                          start_req,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    token_kind,
	output logic [fdtp_pkg::OFF_W-1:0]    name_offset,
	output logic [fdtp_pkg::OFF_W-1:0]    data_offset,
	output logic [fdtp_pkg::LEN_W-1:0]    data_length,
	output logic                          last_of_run
);
	import fdtp_pkg::*;

	logic [CFG_W-1:0]   struct_bytes_q, strings_bytes_q;
	logic               valid_s1, start_s1;
	logic [WORD_W-1:0]  word_s1;
	logic               room, advance;
	push_t              push;
	result_t            head;

	// size registers: the user must write them only while the block is idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			struct_bytes_q  <= '0;
			strings_bytes_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STRUCT_BYTES:  struct_bytes_q  <= cfg_data;
				CFG_STRINGS_BYTES: strings_bytes_q <= cfg_data;
			endcase
		end
	end

	// input register: advance into the parser whenever the queue can take
	// a full run of two tokens
	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// hold the word until it is parsed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1  <= word;
			start_s1 <= start_req;
		end
	end

	fdtp_parse #(
		.MAX_BLOB_BYTES (MAX_BLOB_BYTES)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.word          (word_s1),
		.start_req     (start_s1),
		.struct_bytes  (struct_bytes_q),
		.strings_bytes (strings_bytes_q),
		.push          (push)
	);

	fdtp_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign token_kind  = head.kind;
	assign name_offset = head.name_offset;
	assign data_offset = head.data_offset;
	assign data_length = head.data_length;
	assign last_of_run = head.last_of_run;

`ifndef SYNTHESIS
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(word_s1) && $stable(start_s1))
		else $error("stalled word left the input register");
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input blocked with an empty input register");
	a_push_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |-> push.n == 2'd0)
		else $error("tokens pushed without a parsed word");
`endif

endmodule

/* tb/fdt_word_pkg.sv */
// ----------------------------------------------------------------------------
// fdt_word_pkg: structure block word codes
// Token words of the device-tree structure block. The stimulus and the token
// checker both use them.
// ----------------------------------------------------------------------------
package fdt_word_pkg;

	localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
	localparam logic [31:0] TOK_END_NODE   = 32'd2;
	localparam logic [31:0] TOK_PROP       = 32'd3;
	localparam logic [31:0] TOK_NOP        = 32'd4;
	localparam logic [31:0] TOK_END        = 32'd9;

endpackage

/* tb/fdt_token_check.sv */
// ----------------------------------------------------------------------------
// fdt_token_check: token predictor and comparator for the structure parser
// Watches the configuration port and both beat channels. Every accepted word
// runs through a local copy of the parser state. The tokens it yields are
// queued in order, and every output beat is compared against the oldest one.
// ----------------------------------------------------------------------------
module fdt_token_check #(
	parameter int unsigned MAX_BLOB_BYTES = 1048576
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [fdtp_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [fdtp_pkg::WORD_W-1:0]   word,
	input  logic                          start_req,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [2:0]                    token_kind,
	input  logic [fdtp_pkg::OFF_W-1:0]    name_offset,
	input  logic [fdtp_pkg::OFF_W-1:0]    data_offset,
	input  logic [fdtp_pkg::LEN_W-1:0]    data_length,
	input  logic                          last_of_run,
	output int                            fails,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import fdtp_pkg::*;
	import fdt_word_pkg::*;

	typedef enum logic [2:0] {
		PH_TOKEN,
		PH_NAME,
		PH_PLEN,
		PH_POFF,
		PH_SKIP,
		PH_DONE,
		PH_ERR
	} phase_t;

	phase_t             phase;
	logic [CFG_W-1:0]   struct_bytes;
	logic [CFG_W-1:0]   strings_bytes;
	logic [POS_W-1:0]   byte_pos;
	logic [SKIP_W-1:0]  skip_left;
	logic [31:0]        held_len;
	logic [OFF_W-1:0]   held_name;
	result_t            tokens_due[$];
	result_t            want;
	int                 fail_cnt;

	function automatic result_t make_token(token_kind_t k, logic [63:0] nm, logic [63:0] doff,
			logic [63:0] dlen);
		result_t t;
		t.kind        = k;
		t.name_offset = nm[OFF_W-1:0];
		t.data_offset = doff[OFF_W-1:0];
		t.data_length = dlen[LEN_W-1:0];
		t.last_of_run = 1'b0;
		return t;
	endfunction

	task automatic clear_parser();
		phase     = PH_TOKEN;
		byte_pos  = '0;
		skip_left = '0;
		held_len  = '0;
		held_name = '0;
	endtask

	// Advance the parser by one word and queue the tokens it gives.
	task automatic parse_word(input logic [31:0] w, input logic start);
		logic [63:0] lim;
		logic [63:0] p;
		logic [63:0] room;
		logic [63:0] padded;
		result_t     run[$];

		if (start)
			clear_parser();
		if (phase == PH_DONE || phase == PH_ERR)
			return;

		lim = (64'(struct_bytes) > 64'(MAX_BLOB_BYTES)) ? 64'(MAX_BLOB_BYTES) : 64'(struct_bytes);
		p   = 64'(byte_pos);

		if (p + 64'd4 > lim) begin
			phase = PH_ERR;
			run.push_back(make_token(KIND_ERROR, 0, 0, 0));
		end else begin
			case (phase)
				PH_TOKEN: begin
					case (w)
						TOK_BEGIN_NODE: begin
							held_name = OFF_W'(p + 64'd4);
							phase     = PH_NAME;
						end
						TOK_END_NODE:
							run.push_back(make_token(KIND_END_NODE, 0, 0, 0));
						TOK_PROP: begin
							if (p + 64'd8 > lim) begin
								phase = PH_ERR;
								run.push_back(make_token(KIND_ERROR, 0, 0, 0));
							end else
								phase = PH_PLEN;
						end
						TOK_NOP: ;
						TOK_END: begin
							phase = PH_DONE;
							run.push_back(make_token(KIND_END, 0, 0, 0));
						end
						default: begin
							phase = PH_ERR;
							run.push_back(make_token(KIND_ERROR, 0, 0, 0));
						end
					endcase
				end
				PH_NAME: begin
					if (w[31:24] == 8'd0 || w[23:16] == 8'd0 || w[15:8] == 8'd0 || w[7:0] == 8'd0) begin
						if (p + 64'd4 >= lim) begin
							phase = PH_ERR;
							run.push_back(make_token(KIND_ERROR, 0, 0, 0));
						end else begin
							phase = PH_TOKEN;
							run.push_back(make_token(KIND_BEGIN_NODE, 64'(held_name), 0, 0));
						end
					end
				end
				PH_PLEN: begin
					// unsigned 64-bit room; a negative room wraps to a large value here
					room   = lim - (p + 64'd8);
					padded = (64'(w) + 64'd3) & ~64'd3;
					if (64'(w) > room || padded > room) begin
						phase = PH_ERR;
						run.push_back(make_token(KIND_ERROR, 0, 0, 0));
					end else begin
						held_len = w;
						phase    = PH_POFF;
					end
				end
				PH_POFF: begin
					if (64'(w) >= 64'(strings_bytes)) begin
						phase = PH_ERR;
						run.push_back(make_token(KIND_ERROR, 0, 0, 0));
					end else begin
						padded = (64'(held_len) + 64'd3) >> 2;
						run.push_back(make_token(KIND_PROPERTY, 64'(w), p + 64'd4, 64'(held_len)));
						skip_left = padded[SKIP_W-1:0];
						phase     = (skip_left != '0) ? PH_SKIP : PH_TOKEN;
					end
				end
				default: begin
					if (skip_left != '0)
						skip_left = skip_left - 1'b1;
					if (skip_left == '0)
						phase = PH_TOKEN;
				end
			endcase

			byte_pos = POS_W'(p + 64'd4);
			if (phase != PH_DONE && phase != PH_ERR && lim - 64'(byte_pos) < 64'd4) begin
				phase = PH_ERR;
				run.push_back(make_token(KIND_ERROR, 0, 0, 0));
			end
		end

		if (run.size() > 0)
			run[run.size()-1].last_of_run = 1'b1;
		foreach (run[i])
			tokens_due.push_back(run[i]);
	endtask

	task automatic compare_field(input string field, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
			fail_cnt++;
		end
	endtask

	initial fail_cnt = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tokens_due.delete();
			struct_bytes  = '0;
			strings_bytes = '0;
			clear_parser();
		end else begin
			// drop each output beat against the oldest queued token
			if (out_valid && out_ready) begin
				if (tokens_due.size() == 0) begin
					$error("token_kind: expected no token, got %0d", token_kind);
					fail_cnt++;
				end else begin
					want = tokens_due.pop_front();
					compare_field("token_kind", 32'(want.kind), 32'(token_kind));
					compare_field("name_offset", 32'(want.name_offset), 32'(name_offset));
					compare_field("data_offset", 32'(want.data_offset), 32'(data_offset));
					compare_field("data_length", 32'(want.data_length), 32'(data_length));
					compare_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_STRUCT_BYTES:  struct_bytes  = cfg_data;
					CFG_STRINGS_BYTES: strings_bytes = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				parse_word(word, start_req);
		end
		fails   <= fail_cnt;
		pending <= tokens_due.size();
	end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: regression bench for fdt_structure_token_parser
// Feeds directed corner words and then randomly built structure blocks, some
// well formed and some broken, through the word channel. Both ends idle at
// random. The token checker beside the parser predicts and compares every
// token beat. This module only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fdtp_pkg::*;
	import fdt_word_pkg::*;

	localparam int unsigned BLOB_MAX    = 1048576;
	localparam int unsigned ITEM_TARGET = 1400;
	localparam int unsigned HOLD_CYCLES = 300;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [0:0]           cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [WORD_W-1:0]    word;
	logic                 start_req;
	logic                 out_valid;
	logic                 out_ready;
	logic [2:0]           token_kind;
	logic [OFF_W-1:0]     name_offset;
	logic [OFF_W-1:0]     data_offset;
	logic [LEN_W-1:0]     data_length;
	logic                 last_of_run;
	int                   fails;
	int                   pending;

	// Idle switches for both ends; long_hold asks the receiver for one long stall.
	bit                   tx_idle_on = 1'b1;
	bit                   rx_idle_on = 1'b1;
	bit                   long_hold  = 1'b0;

	// Block under construction: words and their start marks.
	logic [31:0]          blk_words[$];
	bit                   blk_start[$];
	int unsigned          blk_struct;
	int unsigned          blk_strings;
	int unsigned          words_sent = 0;

	fdt_structure_token_parser #(.MAX_BLOB_BYTES(BLOB_MAX)) dut (.*);

	fdt_token_check #(.MAX_BLOB_BYTES(BLOB_MAX)) tok_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one word, hold it until the beat is taken, then maybe idle a while.
	task automatic send_word(input logic [31:0] w, input bit s);
		in_valid  <= 1'b1;
		word      <= w;
		start_req <= s;
		do
			@(posedge clk);
		while (!in_ready);
		if (tx_idle_on && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic queue_word(input logic [31:0] w, input bit s);
		blk_words.push_back(w);
		blk_start.push_back(s);
	endtask

	task automatic stream_block();
		foreach (blk_words[i])
			send_word(blk_words[i], blk_start[i]);
		blk_words.delete();
		blk_start.delete();
	endtask

	// Drop valid and wait until every predicted token has left the parser.
	// The extra cycles cover words still in flight that give no token.
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// Write both size registers on back-to-back cycles, only while idle.
	task automatic set_sizes(input int unsigned sb, input int unsigned strb);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_STRUCT_BYTES;
		cfg_data  <= CFG_W'(sb);
		@(posedge clk);
		cfg_index <= CFG_STRINGS_BYTES;
		cfg_data  <= CFG_W'(strb);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Build one random structure block plus the sizes to run it with. Mostly
	// well formed: nodes with padded names, properties with values, NOPs, a
	// closing end token. A few words are noise, lengths or name offsets out of
	// range, or a start mark in the middle. The size register is usually the
	// exact block size, sometimes short, unaligned, long or an extreme.
	task automatic build_block();
		int unsigned r;
		int unsigned len;
		int unsigned total;
		logic [31:0] w;
		bit          with_end;

		r = $urandom_range(0, 99);
		if (r < 5)
			blk_strings = 0;
		else if (r < 10)
			blk_strings = $urandom_range(1048576, 2097151);
		else
			blk_strings = $urandom_range(1, 4096);

		repeat ($urandom_range(1, 12)) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				queue_word(TOK_NOP, $urandom_range(0, 99) == 0);
			end else if (r < 35) begin
				// node name: whole words of nonzero bytes, then one holding the terminator
				queue_word(TOK_BEGIN_NODE, $urandom_range(0, 99) == 0);
				repeat ($urandom_range(0, 3))
					queue_word({8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
						8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))}, 1'b0);
				w = $urandom;
				case ($urandom_range(0, 3))
					0:       w[31:24] = 8'd0;
					1:       w[23:16] = 8'd0;
					2:       w[15:8]  = 8'd0;
					default: w[7:0]   = 8'd0;
				endcase
				queue_word(w, 1'b0);
			end else if (r < 55) begin
				queue_word(TOK_END_NODE, $urandom_range(0, 99) == 0);
			end else if (r < 94) begin
				queue_word(TOK_PROP, $urandom_range(0, 99) == 0);
				r = $urandom_range(0, 99);
				if (r < 70)
					len = $urandom_range(0, 16);
				else if (r < 92)
					len = $urandom_range(17, 80);
				else if (r < 97)
					len = $urandom_range(81, 600);
				else
					len = $urandom;
				queue_word(len, 1'b0);
				r = $urandom_range(0, 99);
				if (blk_strings > 0 && r < 85)
					queue_word($urandom_range(0, blk_strings - 1), 1'b0);
				else if (r < 92)
					queue_word(blk_strings + $urandom_range(0, 2), 1'b0);
				else
					queue_word($urandom, 1'b0);
				if (len <= 600)
					repeat ((len + 3) / 4) queue_word($urandom, 1'b0);
			end else begin
				queue_word($urandom, 1'b0);
			end
		end

		with_end = $urandom_range(0, 99) < 90;
		if (with_end)
			queue_word(TOK_END, 1'b0);
		total = blk_words.size() * 4;
		words_sent += blk_words.size();

		r = $urandom_range(0, 99);
		if (r < 65)
			blk_struct = total;
		else if (r < 75)
			blk_struct = total + $urandom_range(1, 3);
		else if (r < 85)
			blk_struct = (total > 12) ? total - $urandom_range(1, 12) : $urandom_range(0, 3);
		else if (r < 95)
			blk_struct = total + $urandom_range(4, 200);
		else begin
			case ($urandom_range(0, 2))
				0:       blk_struct = 0;
				1:       blk_struct = BLOB_MAX;
				default: blk_struct = 2097151;
			endcase
		end

		// trailing words after the end token; the parser must ignore them
		if (with_end && $urandom_range(0, 99) < 30)
			repeat ($urandom_range(1, 3)) queue_word($urandom, 1'b0);
		blk_start[0] = 1'b1;
	endtask

	// Receiver: mostly ready, random stalls, and one long hold
	// counted here while the sender keeps offering words.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else
				out_ready <= !(rx_idle_on && $urandom_range(0, 99) < 8);
		end
	end

	initial begin
		#20_000_000;
		$display("fdt_structure_token_parser regression: fail");
		$finish;
	end

	initial begin
		int unsigned blk_no;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_STRUCT_BYTES;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		word      <= '0;
		start_req <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes are zero: with no start mark the first word is already
		// past the block end. The error is sticky, so the next word gives nothing.
		send_word(TOK_END, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		settle();

		// Sizes above the blob limit clamp. Cover every token kind, a name offset
		// wider than the output field, an unknown token, a sticky end, an oversized
		// length and a name offset equal to the strings size.
		set_sizes(2097151, 2097151);
		queue_word(TOK_NOP, 1'b1);
		queue_word(TOK_BEGIN_NODE, 1'b0);
		queue_word(32'h6E6F_6400, 1'b0);
		queue_word(TOK_PROP, 1'b0);
		queue_word(32'd5, 1'b0);
		queue_word(32'd7, 1'b0);
		queue_word(32'h0102_0304, 1'b0);
		queue_word(32'h0500_0000, 1'b0);
		queue_word(TOK_PROP, 1'b0);
		queue_word(32'd0, 1'b0);
		queue_word(32'h001F_FFFE, 1'b0);
		queue_word(TOK_END_NODE, 1'b0);
		queue_word(32'hDEAD_BEEF, 1'b0);
		queue_word(TOK_END, 1'b1);
		queue_word(TOK_END_NODE, 1'b0);
		queue_word(TOK_PROP, 1'b1);
		queue_word(32'hFFFF_FFFC, 1'b0);
		queue_word(TOK_PROP, 1'b1);
		queue_word(32'd4, 1'b0);
		queue_word(32'h001F_FFFF, 1'b0);
		stream_block();
		settle();

		// Unaligned 6-byte block: a token followed by an error in the same word,
		// then a property header that cannot fit.
		set_sizes(6, 0);
		queue_word(TOK_END_NODE, 1'b1);
		queue_word(TOK_PROP, 1'b1);
		stream_block();
		settle();

		// 12-byte block: an empty property ending the block, then a node name
		// whose padded end reaches the block end.
		set_sizes(12, 1);
		queue_word(TOK_PROP, 1'b1);
		queue_word(32'd0, 1'b0);
		queue_word(32'd0, 1'b0);
		queue_word(TOK_BEGIN_NODE, 1'b1);
		queue_word(32'h1122_3344, 1'b0);
		queue_word(32'd0, 1'b0);
		stream_block();
		settle();

		// Random blocks. Blocks 20 to 34 run with no idling on either end.
		// Block 10 is followed by the long receiver hold.
		blk_no = 0;
		while (words_sent < ITEM_TARGET) begin
			blk_no++;
			tx_idle_on = !(blk_no >= 20 && blk_no < 35);
			rx_idle_on = tx_idle_on;
			build_block();
			// reconfigure only when idle; otherwise keep the previous sizes
			if (blk_no == 1 || $urandom_range(0, 99) < 65) begin
				settle();
				set_sizes(blk_struct, blk_strings);
			end
			stream_block();

			if (blk_no == 10) begin
				// Fill the result queue: one token per word while out_ready is held
				// low, so in_ready must drop. Then pause until all tokens are out.
				settle();
				set_sizes(BLOB_MAX, 64);
				@(negedge clk);
				long_hold = 1'b1;
				@(posedge clk);
				queue_word(TOK_END_NODE, 1'b1);
				repeat (40) queue_word(TOK_END_NODE, 1'b0);
				queue_word(TOK_END, 1'b0);
				words_sent += 42;
				stream_block();
				settle();
			end
		end

		// Small block: one property value fills it up to a final empty
		// property that ends exactly at the block end, then the end of the
		// block comes without an end token.
		settle();
		set_sizes(64, 1);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		send_word(TOK_PROP, 1'b1);
		send_word(32'd40, 1'b0);
		send_word(32'd0, 1'b0);
		repeat (10) send_word($urandom, 1'b0);
		send_word(TOK_PROP, 1'b0);
		send_word(32'd0, 1'b0);
		send_word(32'd0, 1'b0);

		// Drain, give late or stray beats time to show up, then report.
		settle();
		repeat (20) @(posedge clk);
		@(negedge clk);
		if (fails == 0)
			$display("fdt_structure_token_parser regression: pass");
		else
			$display("fdt_structure_token_parser regression: fail");
		$finish;
	end

endmodule
